/* sv/npcs_pkg.sv */
// Package for the nearest palette colour search unit.
// Holds item structs, FSM state type, controller/datapath interface structs and constants.
// No dependencies.
`default_nettype none

package npcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = 9;
  localparam int CH_W = 8;
  localparam int ENTRY_W = 3 * CH_W;
  localparam int SQ_W = 2 * CH_W;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W = SQ_W + WEIGHT_W;
  localparam int DIST_W = 16;
  localparam int OUT_IDX_W = 8;
  localparam int W_SHIFT = 16;

  localparam logic [WEIGHT_W-1:0] W_RED = 16'd19595;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd38470;
  localparam logic [WEIGHT_W-1:0] W_BLUE = 16'd7471;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [7:0]      entry_index;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] best_index;
    logic [DIST_W-1:0]    best_distance;
    logic                 found;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic write_entry;
    logic start_query;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* sv/npcs_ctrl.sv */
// Controller state machine of the nearest palette colour search unit.
// Sequences loads, the palette scan, pipeline drain and result hand-off.
// Depends on npcs_pkg.
`default_nettype none

module npcs_ctrl
  import npcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_mode,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd,
  output logic            in_stall
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_mode == MODE_QUERY)) begin
          state_nxt = status.count_zero ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.write_entry = in_valid && (in_mode == MODE_LOAD);
        cmd.start_query = in_valid && (in_mode == MODE_QUERY);
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_DONE: begin
        cmd.finish = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/npcs_datapath.sv */
// Datapath of the nearest palette colour search unit.
// Holds the palette memory, the distance pipeline, the running minimum and the output register.
// Depends on npcs_pkg.
`default_nettype none

module npcs_datapath
  import npcs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_write,
  input  wire logic [CNT_W-1:0] cfg_data,
  input  wire in_item_t        in_item,
  input  wire ctrl_cmd_t       cmd,
  input  wire logic            out_stall,
  output dp_status_t           status,
  output logic                 out_valid,
  output out_item_t            out_item
);

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];

  logic [CNT_W-1:0] active_entries_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_sat;
  logic [IDX_W-1:0] scan_idx_r;
  logic [CH_W-1:0]  q_red_r;
  logic [CH_W-1:0]  q_green_r;
  logic [CH_W-1:0]  q_blue_r;

  logic [ENTRY_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   idx1_r;
  logic [IDX_W-1:0]   idx2_r;
  logic [IDX_W-1:0]   idx3_r;
  logic               v1_r;
  logic               v2_r;
  logic               v3_r;
  logic [SQ_W-1:0]    sq_red_r;
  logic [SQ_W-1:0]    sq_green_r;
  logic [SQ_W-1:0]    sq_blue_r;
  logic [PROD_W-1:0]  wp_red_r;
  logic [PROD_W-1:0]  wp_green_r;
  logic [PROD_W-1:0]  wp_blue_r;
  logic [PROD_W-1:0]  sum;
  logic [DIST_W-1:0]  cand_dist;

  logic               any_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [IDX_W-1:0]   best_i_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  assign count_sat = (active_entries_r > CNT_W'(PALETTE_DEPTH)) ?
                     CNT_W'(PALETTE_DEPTH) : active_entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_entries_r <= '0;
    end else if (cfg_write) begin
      active_entries_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_entry && (CNT_W'(in_item.entry_index) < CNT_W'(PALETTE_DEPTH))) begin
      mem[in_item.entry_index[IDX_W-1:0]] <= {in_item.red, in_item.green, in_item.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      q_red_r <= in_item.red;
      q_green_r <= in_item.green;
      q_blue_r <= in_item.blue;
      count_r <= count_sat;
      scan_idx_r <= '0;
    end else if (cmd.issue) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    idx1_r <= scan_idx_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    sq_red_r <= sq_diff(rd_data_r[3*CH_W-1:2*CH_W], q_red_r);
    sq_green_r <= sq_diff(rd_data_r[2*CH_W-1:CH_W], q_green_r);
    sq_blue_r <= sq_diff(rd_data_r[CH_W-1:0], q_blue_r);
    wp_red_r <= PROD_W'(sq_red_r) * PROD_W'(W_RED);
    wp_green_r <= PROD_W'(sq_green_r) * PROD_W'(W_GREEN);
    wp_blue_r <= PROD_W'(sq_blue_r) * PROD_W'(W_BLUE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // The three products together never exceed 255*255 << 16, so the sum fits.
  assign sum = wp_red_r + wp_green_r + wp_blue_r;
  assign cand_dist = sum[W_SHIFT +: DIST_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
      best_d_r <= '0;
      best_i_r <= '0;
    end else if (cmd.start_query) begin
      any_r <= 1'b0;
      best_d_r <= '0;
      best_i_r <= '0;
    end else if (v3_r && (!any_r || (cand_dist < best_d_r))) begin
      any_r <= 1'b1;
      best_d_r <= cand_dist;
      best_i_r <= idx3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item_r.best_index <= OUT_IDX_W'(best_i_r);
      out_item_r.best_distance <= best_d_r;
      out_item_r.found <= any_r;
    end
  end

  assign status.count_zero = (count_sat == '0);
  assign status.last_issue = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);
  assign status.pipe_busy = v1_r || v2_r || v3_r;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

endmodule

`default_nettype wire

/* sv/nearest_palette_colour_search_unit.sv */
// Nearest palette colour search unit, top level. Depends on npcs_pkg, npcs_ctrl, npcs_datapath.
// A load beat writes one palette entry and is followed by the next beat at once.
// A query scans N = min(active_entries, 256) entries, one memory read per cycle, through a
// distance pipeline; input stays stalled until its result is loaded into the output register.
// Synchronous active-low reset clears control state and active_entries; palette stays unwritten.
`default_nettype none

module nearest_palette_colour_search_unit
  import npcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  npcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  npcs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // A query beat blocks further input on the next cycle.
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_item.mode == MODE_QUERY)) |=> in_stall)
    else $error("input accepted while a query is in flight");

  // A result with no entry searched carries zero index and distance.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |->
      ((out_item.best_index == '0) && (out_item.best_distance == '0)))
    else $error("empty search returned a nonzero result");

  // The weighted distance never exceeds the largest squared channel difference.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.best_distance <= 16'd65025))
    else $error("distance out of range");

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for nearest_palette_colour_search_unit.
// A directed table, then random load/query traffic, checked against the table's expected
// results or a local nearest-colour predictor. Depends on npcs_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb
  import npcs_pkg::*;
();

  localparam logic [31:0] LUMA_R = 32'd19595;
  localparam logic [31:0] LUMA_G = 32'd38470;
  localparam logic [31:0] LUMA_B = 32'd7471;
  localparam int BEAT_TARGET = 1250;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CNT_W-1:0] active;
    in_item_t         beat;
    logic             typed;
    out_item_t        want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  logic [23:0]      pal_model [PALETTE_DEPTH];
  logic [CNT_W-1:0] active_model = '0;
  out_item_t        match_q [$];
  out_item_t        oldest;
  dir_row_t         dir_rows [$];
  int               errors = 0;
  int               beats_sent = 0;
  int               idle_pct = 16;

  nearest_palette_colour_search_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  function automatic int search_span(logic [CNT_W-1:0] n);
    return (n > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(n);
  endfunction

  function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic out_item_t nearest_match(in_item_t q);
    out_item_t        res;
    logic [31:0]      dr, dg, db, acc;
    logic [15:0]      cand_dist;
    logic [IDX_W-1:0] slot;
    int               span;
    res = '0;
    span = search_span(active_model);
    for (int i = 0; i < span; i++) begin
      slot = IDX_W'(i);
      dr = {24'd0, abs_diff(pal_model[slot][23:16], q.red)};
      dg = {24'd0, abs_diff(pal_model[slot][15:8], q.green)};
      db = {24'd0, abs_diff(pal_model[slot][7:0], q.blue)};
      acc = dr * dr * LUMA_R + dg * dg * LUMA_G + db * db * LUMA_B;
      cand_dist = acc[31:16];
      if (!res.found || cand_dist < res.best_distance) begin
        res.found = 1'b1;
        res.best_distance = cand_dist;
        res.best_index = i[7:0];
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] rand_chan();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  function automatic dir_row_t load_row(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b);
    dir_row_t row;
    row.kind = ROW_BEAT;
    row.active = '0;
    row.beat = '{mode: MODE_LOAD, entry_index: idx, red: r, green: g, blue: b};
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t query_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic typed, logic [7:0] wi, logic [15:0] wd,
                                         logic wf);
    dir_row_t row;
    row.kind = ROW_BEAT;
    row.active = '0;
    row.beat = '{mode: MODE_QUERY, entry_index: 8'd0, red: r, green: g, blue: b};
    row.typed = typed;
    row.want = '{best_index: wi, best_distance: wd, found: wf};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CNT_W-1:0] n);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.active = n;
    row.beat = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // in_valid still high, so back-to-back beats need no extra assignment.
  task automatic send_beat(input in_item_t beat, input logic typed, input out_item_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (beat.mode == MODE_LOAD) begin
      pal_model[beat.entry_index] = {beat.red, beat.green, beat.blue};
    end else begin
      match_q.push_back(typed ? want : nearest_match(beat));
    end
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (match_q.size() != 0) @(negedge clk);
    repeat (search_span(active_model) + 8) @(negedge clk);
  endtask

  task automatic write_active(input logic [CNT_W-1:0] n);
    drain_and_settle();
    cfg_data <= n;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    active_model = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (match_q.size() == 0) begin
        $error("result beat with nothing expected: %p", out_item);
        errors++;
      end else begin
        oldest = match_q.pop_front();
        if (out_item.best_index !== oldest.best_index) begin
          $error("best_index expected %0d actual %0d", oldest.best_index, out_item.best_index);
          errors++;
        end
        if (out_item.best_distance !== oldest.best_distance) begin
          $error("best_distance expected %0d actual %0d", oldest.best_distance,
                 out_item.best_distance);
          errors++;
        end
        if (out_item.found !== oldest.found) begin
          $error("found expected %0d actual %0d", oldest.found, out_item.found);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("nearest_palette_colour_search_unit: mismatch");
    $finish;
  end

  initial begin
    int               phase;
    int               pick;
    int               batch;
    int               span;
    logic [CNT_W-1:0] n_next;
    in_item_t         beat;
    logic [23:0]      src;

    dir_rows.push_back(query_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 16'd0, 1'b0));
    dir_rows.push_back(load_row(8'd0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(load_row(8'd1, 8'd255, 8'd255, 8'd255));
    dir_rows.push_back(load_row(8'd2, 8'd255, 8'd0, 8'd0));
    dir_rows.push_back(load_row(8'd3, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(load_row(8'd4, 8'd0, 8'd255, 8'd0));
    dir_rows.push_back(load_row(8'd5, 8'd0, 8'd0, 8'd255));
    dir_rows.push_back(load_row(8'd255, 8'd128, 8'd64, 8'd32));
    dir_rows.push_back(cfg_row(9'd1));
    dir_rows.push_back(query_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 16'd65025, 1'b1));
    dir_rows.push_back(query_row(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 16'd0, 1'b1));
    dir_rows.push_back(cfg_row(9'd6));
    dir_rows.push_back(query_row(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 16'd0, 1'b1));
    dir_rows.push_back(query_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd1, 16'd0, 1'b1));
    dir_rows.push_back(query_row(8'd255, 8'd0, 8'd0, 1'b1, 8'd2, 16'd0, 1'b1));
    dir_rows.push_back(query_row(8'd0, 8'd255, 8'd0, 1'b1, 8'd4, 16'd0, 1'b1));
    dir_rows.push_back(query_row(8'd0, 8'd0, 8'd255, 1'b1, 8'd5, 16'd0, 1'b1));
    dir_rows.push_back(query_row(8'd128, 8'd128, 8'd128, 1'b0, 8'd0, 16'd0, 1'b0));
    dir_rows.push_back(query_row(8'd200, 8'd10, 8'd90, 1'b0, 8'd0, 16'd0, 1'b0));
    dir_rows.push_back(cfg_row(9'd0));
    dir_rows.push_back(query_row(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 16'd0, 1'b0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_active(dir_rows[k].active);
      end else begin
        send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // Fill the whole palette so that any later search reads written entries only.
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      beat = '{mode: MODE_LOAD, entry_index: i[7:0], red: rand_chan(), green: rand_chan(),
               blue: rand_chan()};
      send_beat(beat, 1'b0, '0);
    end

    phase = 0;
    while (beats_sent < BEAT_TARGET) begin
      idle_pct = (phase >= 8 && phase < 14) ? 0 : 16;
      case (phase)
        0: n_next = 9'd256;
        1: n_next = 9'd511;
        default: begin
          pick = $urandom_range(99);
          if (pick < 5) n_next = 9'd0;
          else if (pick < 10) n_next = 9'd256;
          else if (pick < 13) n_next = 9'($urandom_range(257, 511));
          else if (pick < 16) n_next = 9'd255;
          else n_next = 9'($urandom_range(1, 24));
        end
      endcase
      write_active(n_next);
      span = search_span(n_next);
      batch = (span > 64) ? 8 : $urandom_range(15, 40);
      repeat (batch) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          beat.mode = MODE_QUERY;
          beat.entry_index = 8'($urandom_range(255));
          if (span > 0 && $urandom_range(99) < 25) begin
            src = pal_model[IDX_W'($urandom_range(span - 1))];
            {beat.red, beat.green, beat.blue} = src;
          end else begin
            beat.red = rand_chan();
            beat.green = rand_chan();
            beat.blue = rand_chan();
          end
        end else begin
          beat.mode = MODE_LOAD;
          beat.entry_index = ($urandom_range(99) < 60 && span > 0) ?
                             8'($urandom_range(span - 1)) : 8'($urandom_range(255));
          if ($urandom_range(99) < 20) begin
            src = pal_model[IDX_W'($urandom_range(PALETTE_DEPTH - 1))];
            {beat.red, beat.green, beat.blue} = src;
          end else begin
            beat.red = rand_chan();
            beat.green = rand_chan();
            beat.blue = rand_chan();
          end
        end
        send_beat(beat, 1'b0, '0);
      end
      phase++;
    end

    drain_and_settle();
    if (errors == 0 && match_q.size() == 0) begin
      $display("nearest_palette_colour_search_unit: match");
    end else begin
      $display("nearest_palette_colour_search_unit: mismatch");
    end
    $finish;
  end

endmodule
